[src/vector3_arith_normalize_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the vector normalize unit
// Concurrent checks sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITH_NORMALIZE_UNIT_MACROS_SVH
`define VECTOR3_ARITH_NORMALIZE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VANU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// expression never holds
`define VANU_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

[src/vanu_pkg.sv]
// ----------------------------------------------------------------------------
// vanu_pkg
// Widths, mode codes, item type and shared helpers of the vector unit.
// ----------------------------------------------------------------------------
package vanu_pkg;

	localparam int CW = 32;                 // component width
	localparam int FB = 16;                 // fraction bits
	localparam int LANES = 3;
	localparam int NW = CW + FB;            // dividend / quotient width
	localparam int PW = 2 * CW;             // product and sum of squares
	localparam int RW = CW;                 // root width
	localparam int CLW = (PW - FB > NW) ? (PW - FB) : NW;
	localparam int SQ_STAGES = RW;
	localparam int DV_STAGES = NW;

	typedef logic [2:0] mode_t;
	localparam mode_t MODE_ADD   = 3'd0;
	localparam mode_t MODE_SUB   = 3'd1;
	localparam mode_t MODE_MUL   = 3'd2;
	localparam mode_t MODE_DIV   = 3'd3;
	localparam mode_t MODE_SCALE = 3'd4;
	localparam mode_t MODE_DIVF  = 3'd5;
	localparam mode_t MODE_LEN   = 3'd6;
	localparam mode_t MODE_NORM  = 3'd7;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_MUL,
		OP_DIV,
		OP_LEN,
		OP_NORM
	} op_t;

	typedef struct packed {
		op_t                         op;
		logic                        three;
		logic [LANES-1:0]            a_neg;
		logic [LANES-1:0]            b_neg;
		logic [LANES-1:0][CW-1:0]    a_mag;
		logic [LANES-1:0][CW-1:0]    b_mag;
	} item_t;

	typedef struct packed {
		logic [CW-1:0] val;
		logic          sat;
	} clamp_t;

	function automatic logic [CW-1:0] mag_fn(input logic [CW-1:0] v);
		return v[CW-1] ? (~v + CW'(1)) : v;
	endfunction

	function automatic clamp_t clamp_fn(input logic neg, input logic [CLW-1:0] mag);
		clamp_t r;
		logic [CLW-1:0] pos_lim;
		pos_lim = CLW'({1'b0, {(CW-1){1'b1}}});
		if (!neg) begin
			if (mag > pos_lim) begin
				r.val = {1'b0, {(CW-1){1'b1}}};
				r.sat = 1'b1;
			end else begin
				r.val = mag[CW-1:0];
				r.sat = 1'b0;
			end
		end else begin
			if (mag > pos_lim + CLW'(1)) begin
				r.val = {1'b1, {(CW-1){1'b0}}};
				r.sat = 1'b1;
			end else begin
				r.val = ~mag[CW-1:0] + CW'(1);
				r.sat = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

[src/vanu_queue.sv]
// ----------------------------------------------------------------------------
// vanu_queue
// Two-entry queue between the front and back parts; drains every cycle.
// ----------------------------------------------------------------------------
module vanu_queue import vanu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item_in,
	output logic  full,
	output logic  head_valid,
	output item_t head_item
);

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        pop;

	assign head_valid = (cnt_q != 2'd0);
	assign pop        = head_valid;
	assign full       = (cnt_q == 2'd2);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= item_in;
	end

endmodule

[src/vanu_front.sv]
// ----------------------------------------------------------------------------
// vanu_front
// Takes requests, holds the axis setting and maps each mode to an op class.
// ----------------------------------------------------------------------------
module vanu_front import vanu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data,
	input  logic                 start,
	input  logic                 full,
	input  logic [2:0]           mode,
	input  logic signed [CW-1:0] a_x,
	input  logic signed [CW-1:0] a_y,
	input  logic signed [CW-1:0] a_z,
	input  logic signed [CW-1:0] b_x,
	input  logic signed [CW-1:0] b_y,
	input  logic signed [CW-1:0] b_z,
	input  logic signed [CW-1:0] factor,
	output logic                 push,
	output item_t                item
);

	logic                     three_q;
	logic [LANES-1:0][CW-1:0] a_v;
	logic [LANES-1:0][CW-1:0] b_v;
	logic [LANES-1:0][CW-1:0] am;
	logic [LANES-1:0][CW-1:0] bm;
	logic [LANES-1:0]         an;
	logic [LANES-1:0]         bn;
	logic [CW-1:0]            fm;

	assign cfg_ready = 1'b1;
	assign push      = start && !full;
	assign a_v       = {a_z, a_y, a_x};
	assign b_v       = {b_z, b_y, b_x};
	assign fm        = mag_fn(factor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			three_q <= 1'b1;
		else if (cfg_valid)
			three_q <= cfg_data;
	end

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			am[k] = mag_fn(a_v[k]);
			bm[k] = mag_fn(b_v[k]);
			an[k] = a_v[k][CW-1];
			bn[k] = b_v[k][CW-1];
		end
		item.op    = OP_ADD;
		item.three = three_q;
		item.a_neg = an;
		item.a_mag = am;
		item.b_neg = bn;
		item.b_mag = bm;
		case (mode)
			MODE_ADD: item.op = OP_ADD;
			MODE_SUB: item.b_neg = ~bn;
			MODE_MUL: item.op = OP_MUL;
			MODE_DIV: item.op = OP_DIV;
			MODE_SCALE: begin
				item.op    = OP_MUL;
				item.b_neg = {LANES{factor[CW-1]}};
				item.b_mag = {LANES{fm}};
			end
			MODE_DIVF: begin
				item.op    = OP_DIV;
				item.b_neg = {LANES{factor[CW-1]}};
				item.b_mag = {LANES{fm}};
			end
			MODE_LEN: begin
				item.op = OP_LEN;
				if (!three_q)
					item.a_mag[2] = '0;
			end
			default: begin
				item.op    = OP_NORM;
				item.b_neg = '0;
				if (!three_q)
					item.a_mag[2] = '0;
			end
		endcase
	end

endmodule

[src/vanu_back.sv]
// ----------------------------------------------------------------------------
// vanu_back
// Execution pipeline: multiply/add, sum of squares, bit-per-stage root,
// bit-per-stage divide and final clamp.
// ----------------------------------------------------------------------------
`include "vector3_arith_normalize_unit_macros.svh"

module vanu_back import vanu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  item_t                in_item,
	output logic                 done,
	output logic signed [CW-1:0] r_x,
	output logic signed [CW-1:0] r_y,
	output logic signed [CW-1:0] r_z,
	output logic [CW-1:0]        magnitude,
	output logic                 divide_fault,
	output logic                 saturated
);

	typedef struct packed {
		op_t                      op;
		logic                     three;
		logic [LANES-1:0]         a_neg;
		logic [LANES-1:0]         b_neg;
		logic [LANES-1:0][CW-1:0] a_mag;
		logic [LANES-1:0][CW-1:0] b_mag;
		logic [LANES-1:0][CW-1:0] dr;
		logic [LANES-1:0]         dsat;
	} ctl_t;

	// stage 1: products and signed sums
	logic                     valid_s1;
	item_t                    item_s1;
	logic [LANES-1:0][PW-1:0] prod_s1;
	logic [LANES-1:0][CW:0]   addm_s1;
	logic [LANES-1:0]         addn_s1;
	logic [LANES-1:0][PW-1:0] prod_c;
	logic [LANES-1:0][CW:0]   addm_c;
	logic [LANES-1:0]         addn_c;
	logic [CW-1:0]            opnd;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			opnd = (in_item.op == OP_LEN || in_item.op == OP_NORM) ?
				in_item.a_mag[k] : in_item.b_mag[k];
			prod_c[k] = PW'(in_item.a_mag[k]) * PW'(opnd);
			if (in_item.a_neg[k] == in_item.b_neg[k]) begin
				addm_c[k] = {1'b0, in_item.a_mag[k]} + {1'b0, in_item.b_mag[k]};
				addn_c[k] = in_item.a_neg[k];
			end else if (in_item.a_mag[k] >= in_item.b_mag[k]) begin
				addm_c[k] = {1'b0, in_item.a_mag[k] - in_item.b_mag[k]};
				addn_c[k] = in_item.a_neg[k];
			end else begin
				addm_c[k] = {1'b0, in_item.b_mag[k] - in_item.a_mag[k]};
				addn_c[k] = in_item.b_neg[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		prod_s1 <= prod_c;
		addm_s1 <= addm_c;
		addn_s1 <= addn_c;
	end

	// stage 2: sum of squares and direct results
	logic          valid_s2;
	ctl_t          ctl_s2;
	logic [PW-1:0] sum_s2;
	ctl_t          ctl_c;
	clamp_t        cl;

	always_comb begin
		ctl_c.op    = item_s1.op;
		ctl_c.three = item_s1.three;
		ctl_c.a_neg = item_s1.a_neg;
		ctl_c.b_neg = item_s1.b_neg;
		ctl_c.a_mag = item_s1.a_mag;
		ctl_c.b_mag = item_s1.b_mag;
		ctl_c.dr    = '0;
		ctl_c.dsat  = '0;
		cl          = '0;
		for (int k = 0; k < LANES; k++) begin
			if (item_s1.op == OP_ADD) begin
				cl = clamp_fn(addn_s1[k], CLW'(addm_s1[k]));
				ctl_c.dr[k]   = cl.val;
				ctl_c.dsat[k] = cl.sat;
			end else if (item_s1.op == OP_MUL) begin
				cl = clamp_fn(item_s1.a_neg[k] ^ item_s1.b_neg[k],
					CLW'(prod_s1[k][PW-1:FB]));
				ctl_c.dr[k]   = cl.val;
				ctl_c.dsat[k] = cl.sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_c;
		sum_s2 <= prod_s1[0] + prod_s1[1] + prod_s1[2];
	end

	// square root, one result bit per stage
	logic          valid_sq [1:SQ_STAGES];
	ctl_t          ctl_sq   [1:SQ_STAGES];
	logic [PW-1:0] rad_sq   [1:SQ_STAGES];
	logic [RW:0]   rem_sq   [1:SQ_STAGES];
	logic [RW-1:0] root_sq  [1:SQ_STAGES];

	for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sqrt
		logic          v_in;
		ctl_t          c_in;
		logic [PW-1:0] rad_in;
		logic [RW:0]   rem_in;
		logic [RW-1:0] root_in;
		logic [RW+2:0] trial;
		logic [RW+2:0] tsub;
		logic [RW+2:0] diff;

		if (i == 0) begin : g_first
			assign v_in    = valid_s2;
			assign c_in    = ctl_s2;
			assign rad_in  = sum_s2;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign v_in    = valid_sq[i];
			assign c_in    = ctl_sq[i];
			assign rad_in  = rad_sq[i];
			assign rem_in  = rem_sq[i];
			assign root_in = root_sq[i];
		end

		assign trial = {rem_in, rad_in[PW-1 -: 2]};
		assign tsub  = {1'b0, root_in, 2'b01};
		assign diff  = trial - tsub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_sq[i+1] <= 1'b0;
			else
				valid_sq[i+1] <= v_in;
		end

		always_ff @(posedge clk) begin
			ctl_sq[i+1] <= c_in;
			rad_sq[i+1] <= {rad_in[PW-3:0], 2'b00};
			if (trial >= tsub) begin
				rem_sq[i+1]  <= diff[RW:0];
				root_sq[i+1] <= {root_in[RW-2:0], 1'b1};
			end else begin
				rem_sq[i+1]  <= trial[RW:0];
				root_sq[i+1] <= {root_in[RW-2:0], 1'b0};
			end
		end
	end

	// restoring divide, one quotient bit per stage, three lanes
	logic                     valid_dv [1:DV_STAGES];
	ctl_t                     ctl_dv   [1:DV_STAGES];
	logic [RW-1:0]            root_dv  [1:DV_STAGES];
	logic [LANES-1:0][CW-1:0] d_dv     [1:DV_STAGES];
	logic [LANES-1:0][CW-1:0] rem_dv   [1:DV_STAGES];
	logic [LANES-1:0][NW-1:0] num_dv   [1:DV_STAGES];

	for (genvar j = 0; j < DV_STAGES; j++) begin : g_div
		logic                     v_in;
		ctl_t                     c_in;
		logic [RW-1:0]            root_in;
		logic [LANES-1:0][CW-1:0] d_in;
		logic [LANES-1:0][CW-1:0] rem_in;
		logic [LANES-1:0][NW-1:0] num_in;
		logic [LANES-1:0][CW:0]   trial;
		logic [LANES-1:0][CW:0]   diff;
		logic [LANES-1:0]         ge;

		if (j == 0) begin : g_first
			assign v_in    = valid_sq[SQ_STAGES];
			assign c_in    = ctl_sq[SQ_STAGES];
			assign root_in = root_sq[SQ_STAGES];
			assign rem_in  = '0;
			always_comb begin
				for (int k = 0; k < LANES; k++) begin
					d_in[k]   = (ctl_sq[SQ_STAGES].op == OP_NORM) ?
						root_sq[SQ_STAGES] : ctl_sq[SQ_STAGES].b_mag[k];
					num_in[k] = {ctl_sq[SQ_STAGES].a_mag[k], {FB{1'b0}}};
				end
			end
		end else begin : g_next
			assign v_in    = valid_dv[j];
			assign c_in    = ctl_dv[j];
			assign root_in = root_dv[j];
			assign d_in    = d_dv[j];
			assign rem_in  = rem_dv[j];
			assign num_in  = num_dv[j];
		end

		always_comb begin
			for (int k = 0; k < LANES; k++) begin
				trial[k] = {rem_in[k], num_in[k][NW-1]};
				diff[k]  = trial[k] - {1'b0, d_in[k]};
				ge[k]    = (trial[k] >= {1'b0, d_in[k]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_dv[j+1] <= 1'b0;
			else
				valid_dv[j+1] <= v_in;
		end

		always_ff @(posedge clk) begin
			ctl_dv[j+1]  <= c_in;
			root_dv[j+1] <= root_in;
			d_dv[j+1]    <= d_in;
			for (int k = 0; k < LANES; k++) begin
				rem_dv[j+1][k] <= ge[k] ? diff[k][CW-1:0] : trial[k][CW-1:0];
				num_dv[j+1][k] <= {num_in[k][NW-2:0], ge[k]};
			end
		end
	end

	// output stage
	logic                     done_q;
	logic [LANES-1:0][CW-1:0] r_q;
	logic [CW-1:0]            magnitude_q;
	logic                     fault_q;
	logic                     sat_q;
	op_t                      out_op_q;
	logic                     out_three_q;
	logic [LANES-1:0][CW-1:0] r_c;
	logic [LANES-1:0]         sat_c;
	logic [LANES-1:0]         flt_c;
	ctl_t                     ce;
	clamp_t                   qc;
	logic                     is_div;

	assign ce     = ctl_dv[DV_STAGES];
	assign is_div = (ce.op == OP_DIV || ce.op == OP_NORM);

	always_comb begin
		qc = '0;
		for (int k = 0; k < LANES; k++) begin
			r_c[k]   = ce.dr[k];
			sat_c[k] = ce.dsat[k];
			flt_c[k] = 1'b0;
			if (is_div) begin
				if (d_dv[DV_STAGES][k] == '0) begin
					r_c[k]   = '0;
					sat_c[k] = 1'b0;
					flt_c[k] = 1'b1;
				end else begin
					qc = clamp_fn(ce.a_neg[k] ^ ce.b_neg[k], CLW'(num_dv[DV_STAGES][k]));
					r_c[k]   = qc.val;
					sat_c[k] = qc.sat;
				end
			end
		end
		// two-axis setting: z lane is dropped entirely
		if (!ce.three) begin
			r_c[2]   = '0;
			sat_c[2] = 1'b0;
			flt_c[2] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= valid_dv[DV_STAGES];
	end

	always_ff @(posedge clk) begin
		r_q         <= r_c;
		fault_q     <= |flt_c;
		sat_q       <= |sat_c;
		magnitude_q <= (ce.op == OP_LEN || ce.op == OP_NORM) ? root_dv[DV_STAGES] : '0;
		out_op_q    <= ce.op;
		out_three_q <= ce.three;
	end

	assign done         = done_q;
	assign r_x          = r_q[0];
	assign r_y          = r_q[1];
	assign r_z          = r_q[2];
	assign magnitude    = magnitude_q;
	assign divide_fault = fault_q;
	assign saturated    = sat_q;

	`VANU_ASSERT_IMPL(a_fault_only_div, done_q && fault_q, out_op_q == OP_DIV || out_op_q == OP_NORM, "divide fault outside divide modes")
	`VANU_ASSERT_IMPL(a_two_axis_z, done_q && !out_three_q, r_q[2] == '0, "z nonzero with two axes")
	`VANU_ASSERT_IMPL(a_norm_zero_len, done_q && out_op_q == OP_NORM && fault_q, magnitude_q == '0, "normalize fault with nonzero length")
	`VANU_ASSERT_NEVER(a_len_no_vec, done_q && out_op_q == OP_LEN && (r_q != '0 || sat_q), "length mode produced a vector")

endmodule

[src/vector3_arith_normalize_unit.sv]
// Throughput: one transaction per cycle; the divide and root pipelines retire one bit
//   per stage (32 root stages, 48 divide stages), so every mode sees the same latency.
// busy rises only when the two-entry front queue is full; the back end never stalls.
// Reset: arst_n clears the pipeline valids and the queue, the axis setting (three_q) returns to 1.
// ----------------------------------------------------------------------------
// vector3_arith_normalize_unit
// Q16.16 three-component vector ALU: add, sub, mul, div, scale, divide by
// factor, length and normalize, with saturation and divide-by-zero flag.
// ----------------------------------------------------------------------------
module vector3_arith_normalize_unit import vanu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           mode,
	input  logic signed [CW-1:0] a_x,
	input  logic signed [CW-1:0] a_y,
	input  logic signed [CW-1:0] a_z,
	input  logic signed [CW-1:0] b_x,
	input  logic signed [CW-1:0] b_y,
	input  logic signed [CW-1:0] b_z,
	input  logic signed [CW-1:0] factor,
	output logic                 done,
	output logic signed [CW-1:0] r_x,
	output logic signed [CW-1:0] r_y,
	output logic signed [CW-1:0] r_z,
	output logic [CW-1:0]        magnitude,
	output logic                 divide_fault,
	output logic                 saturated
);

	logic  push;
	logic  full;
	item_t item;
	logic  head_valid;
	item_t head_item;

	assign busy = full;

	vanu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.start     (start),
		.full      (full),
		.mode      (mode),
		.a_x       (a_x),
		.a_y       (a_y),
		.a_z       (a_z),
		.b_x       (b_x),
		.b_y       (b_y),
		.b_z       (b_z),
		.factor    (factor),
		.push      (push),
		.item      (item)
	);

	vanu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item_in    (item),
		.full       (full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	vanu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (head_valid),
		.in_item      (head_item),
		.done         (done),
		.r_x          (r_x),
		.r_y          (r_y),
		.r_z          (r_z),
		.magnitude    (magnitude),
		.divide_fault (divide_fault),
		.saturated    (saturated)
	);

endmodule
